// ===== src/mks_pkg.sv =====
// Shared types, constants and the key code table for the keypad scanner.
package mks_pkg;

    localparam int ROW_COUNT = 4;
    localparam int COL_COUNT = 4;
    localparam int CODE_W = 5;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [ROW_COUNT-1:0] ALL_ROWS_HIGH = 4'hF;
    localparam logic [COL_COUNT-1:0] NO_COLUMN_DRIVEN = 4'hF;
    localparam logic [CODE_W-1:0] NO_KEY = 5'd0;

    typedef struct packed {
        logic [COL_COUNT-1:0] column_drive;
        logic                 key_valid;
        logic [CODE_W-1:0]    key_code;
    } mks_result_t;

    // Key code lookup by row and column.
    function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] row,
                                                     input logic [1:0] col);
        logic [CODE_W-1:0] code;
        unique case ({row, col})
            4'h0: code = 5'd1;
            4'h1: code = 5'd2;
            4'h2: code = 5'd3;
            4'h3: code = 5'd10;
            4'h4: code = 5'd4;
            4'h5: code = 5'd5;
            4'h6: code = 5'd6;
            4'h7: code = 5'd11;
            4'h8: code = 5'd7;
            4'h9: code = 5'd8;
            4'hA: code = 5'd9;
            4'hB: code = 5'd12;
            4'hC: code = 5'd14;
            4'hD: code = 5'd16;
            4'hE: code = 5'd15;
            default: code = 5'd13;
        endcase
        return code;
    endfunction

endpackage

// ===== src/mks_in_stage.sv =====
// Input register stage holding one scan tick of sampled row levels.
module mks_in_stage
    import mks_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ROW_COUNT-1:0] s_rows,
    input  logic                 advance,
    output logic                 item_valid,
    output logic [ROW_COUNT-1:0] item_rows
);

    logic                 valid_reg;
    logic [ROW_COUNT-1:0] rows_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_rows  = rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            rows_reg <= s_rows;
        end
    end

endmodule

// ===== src/mks_scan_core.sv =====
// Scan state, debounce counter and key decode for one tick.
module mks_scan_core
    import mks_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [COUNT_W-1:0]   cfg_data,
    input  logic                 advance,
    input  logic [ROW_COUNT-1:0] rows,
    output mks_result_t          result
);

    logic [COUNT_W-1:0]   debounce_reg;
    logic                 sense_phase_reg, sense_phase_next;
    logic [1:0]           scan_column_reg, scan_column_next;
    logic [COUNT_W-1:0]   held_count_reg, held_count_next;
    logic                 press_locked_reg, press_locked_next;
    logic [COL_COUNT-1:0] drive_pattern_reg, drive_pattern_next;

    logic [COUNT_W-1:0]   limit;
    logic [1:0]           first_low;
    logic                 any_low;

    assign limit = (debounce_reg == '0) ? COUNT_W'(1) : debounce_reg;

    // Priority search for the first pressed row, row one first.
    always_comb begin
        first_low = 2'd0;
        any_low   = 1'b0;
        for (int r = ROW_COUNT - 1; r >= 0; r--) begin
            if (!rows[r]) begin
                first_low = 2'(r);
                any_low   = 1'b1;
            end
        end
    end

    always_comb begin
        sense_phase_next   = sense_phase_reg;
        scan_column_next   = scan_column_reg;
        held_count_next    = held_count_reg;
        press_locked_next  = press_locked_reg;
        drive_pattern_next = drive_pattern_reg;
        result.key_valid   = 1'b0;
        result.key_code    = NO_KEY;
        if (!sense_phase_reg) begin
            drive_pattern_next = ~(COL_COUNT'(1) << scan_column_reg);
            sense_phase_next   = 1'b1;
        end else if (rows == ALL_ROWS_HIGH) begin
            scan_column_next  = scan_column_reg + 2'd1;
            held_count_next   = '0;
            press_locked_next = 1'b0;
            sense_phase_next  = 1'b0;
        end else if (!press_locked_reg) begin
            if (held_count_reg != COUNT_MAX) begin
                held_count_next = held_count_reg + COUNT_W'(1);
            end
            if (held_count_next >= limit) begin
                press_locked_next = 1'b1;
                result.key_valid  = any_low;
                result.key_code   = key_lookup(first_low, scan_column_reg);
            end
        end
        result.column_drive = drive_pattern_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_write) begin
            debounce_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sense_phase_reg   <= 1'b0;
            scan_column_reg   <= 2'd0;
            held_count_reg    <= '0;
            press_locked_reg  <= 1'b0;
            drive_pattern_reg <= NO_COLUMN_DRIVEN;
        end else if (advance) begin
            sense_phase_reg   <= sense_phase_next;
            scan_column_reg   <= scan_column_next;
            held_count_reg    <= held_count_next;
            press_locked_reg  <= press_locked_next;
            drive_pattern_reg <= drive_pattern_next;
        end
    end

`ifndef SYNTHESIS
    a_code_with_report: assert property (@(posedge aclk) disable iff (!aresetn)
        result.key_valid |-> (result.key_code != NO_KEY))
        else $error("key report without a key code");

    a_report_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.key_valid) |=> press_locked_reg)
        else $error("lock not set after a key report");

    a_report_only_unlocked: assert property (@(posedge aclk) disable iff (!aresetn)
        result.key_valid |-> (sense_phase_reg && !press_locked_reg))
        else $error("key report outside an unlocked sense tick");

    a_drive_one_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !sense_phase_reg) |=>
            (sense_phase_reg && $countones(drive_pattern_reg) == COL_COUNT - 1))
        else $error("drive tick did not drive exactly one column");
`endif

endmodule

// ===== src/mks_out_stage.sv =====
// Result register stage; takes a new result whenever the slot is free or draining.
module mks_out_stage
    import mks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  mks_result_t result,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output mks_result_t m_result
);

    logic        valid_reg;
    mks_result_t result_reg;

    assign advance  = item_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

// ===== src/matrix_keypad_scanner_top.sv =====
// Top level of the 4x4 keypad scanner with debounce.
//
//  Channel  Direction  Signals                     Contents
//  s_       in         s_tvalid/s_tready/s_tdata   one scan tick of row levels
//  m_       out        m_tvalid/m_tready/m_tdata   column drive, key code, key flag
//  cfg_     in         cfg_valid/cfg_ready/cfg_data debounce_ticks register
//
// Each tick passes an input register and a result register; one tick is
// accepted per cycle when m_tready stays high.
// aresetn is synchronous, active low; it restores the drive phase, column one
// and a debounce threshold of five. A stall on m_tready holds the result and
// lets one more tick wait in the input register before s_tready drops.
module matrix_keypad_scanner_top
    import mks_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [3:0] row_levels, [7:4] ignored
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [3:0] column_drive, [8:4] key_code, [15:9] zero
    output logic         m_tuser,   // [0] key_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data   // debounce_ticks
);

    logic                 advance;
    logic                 item_valid;
    logic [ROW_COUNT-1:0] item_rows;
    mks_result_t          core_result;
    mks_result_t          out_result;

    assign cfg_ready = 1'b1;

    mks_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_rows     (s_tdata[ROW_COUNT-1:0]),
        .advance    (advance),
        .item_valid (item_valid),
        .item_rows  (item_rows)
    );

    mks_scan_core u_scan_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .rows      (item_rows),
        .result    (core_result)
    );

    mks_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (core_result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (out_result)
    );

    assign m_tdata = {7'd0, out_result.key_code, out_result.column_drive};
    assign m_tuser = out_result.key_valid;

endmodule

// ===== tb/sv/matrix_keypad_scanner_top_tb.sv =====
// Self-checking testbench for the 4x4 keypad scanner: directed scan table, then random key presses.
`timescale 1ns / 1ps

module matrix_keypad_scanner_top_tb;
    import mks_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // One row of the directed scan table.
    typedef struct packed {
        logic [3:0]  rows;
        logic [3:0]  pad;
        logic        typed;
        mks_result_t want;
    } scan_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic       m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // Scanner model state.
    logic                 scan_sensing = 1'b0;
    logic [1:0]           scan_col = 2'd0;
    logic [COUNT_W-1:0]   held_ticks = '0;
    logic                 key_locked = 1'b0;
    logic [COL_COUNT-1:0] drive_cols = NO_COLUMN_DRIVEN;
    logic [COUNT_W-1:0]   debounce_thr = DEBOUNCE_RESET;

    // Key codes indexed by {row, column}.
    logic [CODE_W-1:0] key_map [16] = '{5'd1, 5'd2, 5'd3, 5'd10,
                                        5'd4, 5'd5, 5'd6, 5'd11,
                                        5'd7, 5'd8, 5'd9, 5'd12,
                                        5'd14, 5'd16, 5'd15, 5'd13};

    mks_result_t scan_results_due[$];
    scan_row_t   scan_script[$];

    int  ticks_sent = 0;
    int  key_reports = 0;
    int  mismatches = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  rx_mode_left = 0;
    int  rx_cycle = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    matrix_keypad_scanner_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Advances the scanner state by one tick and returns the result it produces.
    task automatic predict_scan(input logic [3:0] rows, output mks_result_t res);
        logic [COUNT_W-1:0] limit;
        bit found;
        res.column_drive = '0;
        res.key_valid = 1'b0;
        res.key_code = NO_KEY;
        found = 1'b0;
        if (!scan_sensing) begin
            drive_cols = ~(4'b0001 << scan_col);
            scan_sensing = 1'b1;
        end else if (rows == ALL_ROWS_HIGH) begin
            scan_col = scan_col + 2'd1;
            held_ticks = '0;
            key_locked = 1'b0;
            scan_sensing = 1'b0;
        end else if (!key_locked) begin
            limit = (debounce_thr == 0) ? 8'd1 : debounce_thr;
            if (held_ticks != COUNT_MAX)
                held_ticks = held_ticks + 8'd1;
            if (held_ticks >= limit) begin
                key_locked = 1'b1;
                for (int r = 0; r < ROW_COUNT; r++) begin
                    if (!rows[r] && !found) begin
                        found = 1'b1;
                        res.key_valid = 1'b1;
                        res.key_code = key_map[{2'(r), scan_col}];
                    end
                end
            end
        end
        res.column_drive = drive_cols;
    endtask

    task automatic add_row(input logic [3:0] rows, input logic [3:0] pad, input logic typed,
                           input logic [3:0] drive, input logic valid,
                           input logic [CODE_W-1:0] code);
        scan_row_t row;
        row.rows = rows;
        row.pad = pad;
        row.typed = typed;
        row.want.column_drive = drive;
        row.want.key_valid = valid;
        row.want.key_code = code;
        scan_script.push_back(row);
    endtask

    // Offers one scan tick, pausing between bursts, and records what it must produce.
    task automatic send_tick(input logic [3:0] rows, input logic [3:0] pad,
                             input logic typed, input mks_result_t want);
        mks_result_t predicted;
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {pad, rows};
        do @(posedge aclk); while (!s_tready);
        predict_scan(rows, predicted);
        scan_results_due.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [7:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        debounce_thr = value;
        cfg_valid <= 1'b0;
    endtask

    // Mostly realistic presses: idle scanning, a held key with some bounce, then release.
    task automatic run_random(input int n_items);
        int stop_at;
        int thr_eff;
        logic [3:0] pattern;
        logic [3:0] rows;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 5)) send_tick(ALL_ROWS_HIGH, 4'h0, 1'b0, '0);
                thr_eff = (debounce_thr == 0) ? 1 : debounce_thr;
                if ($urandom_range(0, 2) != 0)
                    pattern = ~(4'b0001 << $urandom_range(0, 3));
                else
                    pattern = 4'($urandom_range(0, 14));
                repeat ($urandom_range(1, thr_eff + 4)) begin
                    rows = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 14)) : pattern;
                    send_tick(rows, 4'h0, 1'b0, '0);
                end
                repeat ($urandom_range(1, 3)) send_tick(ALL_ROWS_HIGH, 4'h0, 1'b0, '0);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_tick(4'($urandom_range(0, 15)), 4'h0, 1'b0, '0);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    endtask

    // Output ready: a long counted hold on request, otherwise a changing stall pattern.
    always @(posedge aclk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= ((rx_cycle % 7) < 4);
            endcase
        end
    end

    always @(posedge aclk) begin
        mks_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser)
                key_reports++;
            if (scan_results_due.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", 0, int'(m_tdata));
            end else begin
                want = scan_results_due.pop_front();
                if (m_tdata[3:0] != want.column_drive)
                    report_mismatch("column_drive", int'(want.column_drive),
                                    int'(m_tdata[3:0]));
                if (m_tuser != want.key_valid)
                    report_mismatch("key_valid", int'(want.key_valid), int'(m_tuser));
                if (m_tdata[8:4] != want.key_code)
                    report_mismatch("key_code", int'(want.key_code), int'(m_tdata[8:4]));
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", scan_results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        // Reset threshold is five; the table walks columns one to four.
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b1, 4'hE, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b1, 4'hE, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b1, 4'hD, 1'b0, NO_KEY);
        repeat (4) add_row(4'hE, 4'h0, 1'b1, 4'hD, 1'b0, NO_KEY);
        add_row(4'hE, 4'h0, 1'b1, 4'hD, 1'b1, 5'd2);
        // All rows low while locked must not report again.
        add_row(4'h0, 4'h0, 1'b1, 4'hD, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b1, 4'hD, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b1, 4'hB, 1'b0, NO_KEY);
        // Nonzero bits above the row field must still read as a release.
        add_row(ALL_ROWS_HIGH, 4'hA, 1'b1, 4'hB, 1'b0, NO_KEY);
        add_row(4'h7, 4'h5, 1'b0, 4'h0, 1'b0, NO_KEY);
        add_row(4'h7, 4'h5, 1'b0, 4'h0, 1'b0, NO_KEY);
        repeat (4) add_row(4'h7, 4'h0, 1'b0, 4'h0, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b0, 4'h0, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b0, 4'h0, 1'b0, NO_KEY);
        repeat (5) add_row(4'hB, 4'h0, 1'b0, 4'h0, 1'b0, NO_KEY);
        add_row(ALL_ROWS_HIGH, 4'h0, 1'b0, 4'h0, 1'b0, NO_KEY);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (scan_script[i])
            send_tick(scan_script[i].rows, scan_script[i].pad, scan_script[i].typed,
                      scan_script[i].want);

        // A zero threshold reports on the first held sense tick.
        set_threshold(8'd0);
        run_random(120);

        // Largest threshold: one long press that runs the held count to its limit.
        set_threshold(8'd255);
        gaps_on = 1'b0;
        repeat (2) send_tick(ALL_ROWS_HIGH, 4'h0, 1'b0, '0);
        repeat (262) send_tick(4'hE, 4'h0, 1'b0, '0);
        send_tick(ALL_ROWS_HIGH, 4'h0, 1'b0, '0);
        gaps_on = 1'b1;

        // Hold the output off while ticks keep coming so the input side backs up.
        set_threshold(8'd1);
        run_random(60);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        run_random(150);
        gaps_on = 1'b1;

        for (int p = 0; p < 5; p++) begin
            set_threshold(8'($urandom_range(2, 12)));
            run_random(120);
            if (p == 2) begin
                // Stop sending until every result is back, then carry on.
                drain_results();
                run_random(60);
            end
        end

        drain_results();
        $display("Sent %0d scan ticks at thresholds 5, 0, 255, 1 and random values up to 12.",
                 ticks_sent);
        $display("Saw %0d key reports; %0d mismatches.", key_reports, mismatches);
        if (mismatches == 0 && scan_results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/mks_pkg.sv
src/mks_in_stage.sv
src/mks_scan_core.sv
src/mks_out_stage.sv
src/matrix_keypad_scanner_top.sv
tb/sv/matrix_keypad_scanner_top_tb.sv
